// ===== design/asrb_pkg.sv =====
// Shared types, constants and helpers of the audio sample ring buffer.
`default_nettype none

package asrb_pkg;

   // Ring geometry
   localparam int RING_BYTES = 65536;
   localparam int PTR_W      = $clog2(RING_BYTES);
   localparam int CNT_W      = $clog2(RING_BYTES + 1);
   localparam int SUM_W      = CNT_W + 1;

   // Peek batch limit
   localparam int BATCH_MAX = 64;
   localparam int BATCH_W   = $clog2(BATCH_MAX + 1);

   // Field widths fixed by the channels
   localparam int FUNC_W   = 2;
   localparam int SLOT_W   = 32;
   localparam int COUNT_W  = 17;
   localparam int BYTE_W   = 8;
   localparam int GAIN_W   = 8;
   localparam int PCM_W    = 16;
   localparam int TOTAL_W  = 32;
   localparam int PROD_W   = PCM_W + GAIN_W + 1;

   // Saturation limits of 16-bit PCM
   localparam logic signed [PROD_W-1:0] PCM_MAX = PROD_W'(32767);
   localparam logic signed [PROD_W-1:0] PCM_MIN = -PROD_W'(32768);

   localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(1);

   // Request function codes
   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUSH   = 2'd0,
      FUNC_PEEK   = 2'd1,
      FUNC_COMMIT = 2'd2,
      FUNC_CLEAR  = 2'd3
   } func_type;

   // Classified request passed from front end to back end
   typedef struct packed {
      func_type           func;
      logic [PCM_W-1:0]   pcm;
      logic [CNT_W-1:0]   count;
   } cmd_type;

   // One response
   typedef struct packed {
      logic [BYTE_W-1:0]  data_byte;
      logic               data_valid;
      logic               last;
      logic [COUNT_W-1:0] count_done;
      logic [COUNT_W-1:0] bytes_used;
      logic [TOTAL_W-1:0] dropped_total;
      logic [TOTAL_W-1:0] recorded_total;
   } rsp_type;

   // Back-end sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PUSH_LO,
      ST_PUSH_HI,
      ST_COMMIT,
      ST_CLEAR,
      ST_PEEK,
      ST_PEEK_DATA,
      ST_RESP
   } state_type;

   // Ring pointer increment with wrap
   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
      return (ptr == PTR_W'(RING_BYTES - 1)) ? '0 : ptr + 1'b1;
   endfunction

endpackage

`default_nettype wire

// ===== design/asrb_if.sv =====
// Channel interfaces: request, response and gain register write.
`default_nettype none

interface asrb_req_if;
   logic                          valid;
   logic                          ready;
   logic [asrb_pkg::FUNC_W-1:0]   func;
   logic [asrb_pkg::SLOT_W-1:0]   sample_slot;
   logic [asrb_pkg::COUNT_W-1:0]  byte_count;

   modport source (output valid, output func, output sample_slot, output byte_count,
                   input ready);
   modport sink   (input valid, input func, input sample_slot, input byte_count,
                   output ready);
endinterface

interface asrb_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [asrb_pkg::BYTE_W-1:0]   data_byte;
   logic                          data_valid;
   logic                          last;
   logic [asrb_pkg::COUNT_W-1:0]  count_done;
   logic [asrb_pkg::COUNT_W-1:0]  bytes_used;
   logic [asrb_pkg::TOTAL_W-1:0]  dropped_total;
   logic [asrb_pkg::TOTAL_W-1:0]  recorded_total;

   modport source (output valid, output data_byte, output data_valid, output last,
                   output count_done, output bytes_used, output dropped_total,
                   output recorded_total, input ready);
   modport sink   (input valid, input data_byte, input data_valid, input last,
                   input count_done, input bytes_used, input dropped_total,
                   input recorded_total, output ready);
endinterface

interface asrb_csr_if;
   logic                          valid;
   logic                          ready;
   logic [asrb_pkg::GAIN_W-1:0]   data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/audio_sample_ring_buffer.sv =====
// Audio sample ring buffer: 16-bit PCM byte FIFO with peek and commit.
//
// Channels: req_bus takes requests (func, sample_slot, byte_count); rsp_bus
// returns responses; csr_bus writes the 8-bit gain (reset value 1). The user
// must write it only while no request is in flight; the block does not enforce it.
// A push converts the slot's upper half times gain, saturated, and stores the
// low then the high byte; bytes that find the ring full are counted as
// dropped. A peek returns up to 64 held bytes without consuming them, the
// final one marked last; an empty peek gives one status response. A commit
// consumes up to the held count; a stream clear zeroes pointers and counters.
// Flow: the request enters a two-entry queue, then the back-end sequencer runs
// it. A push passes states PUSH_LO, PUSH_HI and RESP; a commit or clear its own
// state and RESP; a peek PEEK, then PEEK_DATA for each byte (RESP if empty).
// The sequencer takes the next request only back in IDLE; peek bytes come one
// per cycle from the single RAM read port while the receiver takes them.
// The single RAM write port also sets the push cost, one byte written per cycle.
// Reset empties the queue and the ring, clears the counters and the response
// valid flag; ring contents stay undefined until written. When the receiver
// holds rsp ready low, the response register holds and the sequencer waits,
// and requests keep being taken until the queue is full.
`default_nettype none

module audio_sample_ring_buffer (
   input  wire logic  clock,
   input  wire logic  reset,
   asrb_req_if.sink   req_bus,
   asrb_rsp_if.source rsp_bus,
   asrb_csr_if.sink   csr_bus
);

   import asrb_pkg::*;

   logic    fq_valid;
   logic    fq_ready;
   cmd_type fq_data;
   logic    qb_valid;
   logic    qb_ready;
   cmd_type qb_data;

   // accept and classify
   asrb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .csr_bus   (csr_bus),
      .cmd_valid (fq_valid),
      .cmd_ready (fq_ready),
      .cmd_data  (fq_data)
   );

   // decoupling queue
   asrb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   (fq_data),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_data  (qb_data)
   );

   // ring sequencer
   asrb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (qb_valid),
      .cmd_ready (qb_ready),
      .cmd_data  (qb_data),
      .rsp_bus   (rsp_bus)
   );

endmodule

`default_nettype wire

// ===== design/asrb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module asrb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/asrb_front.sv =====
// Front end: gain register, request acceptance, PCM conversion and classification.
`default_nettype none

module asrb_front (
   input  wire logic              clock,
   input  wire logic              reset,
   asrb_req_if.sink               req_bus,
   asrb_csr_if.sink               csr_bus,
   output logic                   cmd_valid,
   input  wire logic              cmd_ready,
   output asrb_pkg::cmd_type      cmd_data
);

   import asrb_pkg::*;

   logic [GAIN_W-1:0]        gain_ff;
   logic [GAIN_W-1:0]        gain_in;
   logic signed [PCM_W-1:0]  sample_hi;
   logic signed [GAIN_W:0]   gain_s;
   logic signed [PROD_W-1:0] product;
   logic [PCM_W-1:0]         pcm_sat;
   logic [CNT_W-1:0]         peek_max;
   func_type                 func;

   // gain register, always ready for writes
   assign csr_bus.ready = 1'b1;
   assign gain_in = csr_bus.valid ? csr_bus.data : gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
      end else begin
         gain_ff <= gain_in;
      end
   end

   // top half of the slot times gain, saturated to 16 bits
   assign sample_hi = signed'(req_bus.sample_slot[SLOT_W-1:SLOT_W-PCM_W]);
   assign gain_s    = signed'({1'b0, gain_ff});
   assign product   = PROD_W'(sample_hi) * PROD_W'(gain_s);

   always_comb begin
      priority if (product > PCM_MAX) begin
         pcm_sat = PCM_MAX[PCM_W-1:0];
      end else if (product < PCM_MIN) begin
         pcm_sat = PCM_MIN[PCM_W-1:0];
      end else begin
         pcm_sat = product[PCM_W-1:0];
      end
   end

   // peek length limited to one batch
   assign peek_max = (CNT_W'(req_bus.byte_count) > CNT_W'(BATCH_MAX)) ?
                     CNT_W'(BATCH_MAX) : CNT_W'(req_bus.byte_count);

   // classify
   assign func = func_type'(req_bus.func);

   always_comb begin
      cmd_data.func = func;
      cmd_data.pcm  = pcm_sat;
      unique case (func)
         FUNC_PEEK:   cmd_data.count = peek_max;
         FUNC_COMMIT: cmd_data.count = CNT_W'(req_bus.byte_count);
         FUNC_PUSH,
         FUNC_CLEAR:  cmd_data.count = '0;
      endcase
   end

   assign cmd_valid     = req_bus.valid;
   assign req_bus.ready = cmd_ready;

endmodule

`default_nettype wire

// ===== design/asrb_queue.sv =====
// Short command queue between front end and back end.
`default_nettype none

module asrb_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire asrb_pkg::cmd_type in_data,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output asrb_pkg::cmd_type      out_data
);

   import asrb_pkg::*;

   localparam int DEPTH  = 2;
   localparam int QPTR_W = $clog2(DEPTH);
   localparam int FILL_W = $clog2(DEPTH + 1);

   cmd_type           ent_ff [DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              push;
   logic              pop;

   assign in_ready  = (fill_ff != FILL_W'(DEPTH));
   assign out_valid = (fill_ff != '0);
   assign out_data  = ent_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // pointer and fill updates
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

`default_nettype wire

// ===== design/asrb_back.sv =====
// Back end: ring sequencer for push, peek, commit and clear, with response register.
`default_nettype none

module asrb_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   output logic                   cmd_ready,
   input  wire asrb_pkg::cmd_type cmd_data,
   asrb_rsp_if.source             rsp_bus
);

   import asrb_pkg::*;

   state_type          state_ff, state_in;
   logic [PTR_W-1:0]   wp_ff, wp_in;
   logic [PTR_W-1:0]   rp_ff, rp_in;
   logic [CNT_W-1:0]   used_ff, used_in;
   logic [TOTAL_W-1:0] dropped_ff, dropped_in;
   logic [TOTAL_W-1:0] recorded_ff, recorded_in;
   cmd_type            cur_ff, cur_in;
   logic [CNT_W-1:0]   done_ff, done_in;
   logic               drop_ff, drop_in;
   logic [BATCH_W-1:0] n_ff, n_in;
   logic [BATCH_W-1:0] idx_ff, idx_in;
   logic [PTR_W-1:0]   p_ff, p_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               out_load;
   logic               full;
   logic               last_byte;
   logic [CNT_W-1:0]   commit_amt;
   logic [CNT_W-1:0]   peek_amt;
   logic [BATCH_W-1:0] peek_n;
   logic [SUM_W-1:0]   rp_sum;
   logic [SUM_W-1:0]   rp_wrap;
   logic               wr_en;
   logic [PTR_W-1:0]   wr_addr;
   logic [BYTE_W-1:0]  wr_data;
   logic               rd_en;
   logic [PTR_W-1:0]   rd_addr;
   logic [BYTE_W-1:0]  rd_data;
   logic               emit;

   // byte store
   asrb_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (RING_BYTES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // shared status
   assign out_load   = !rsp_valid_ff || rsp_bus.ready;
   assign full       = (used_ff == CNT_W'(RING_BYTES));
   assign last_byte  = ((idx_ff + BATCH_W'(1)) == n_ff);
   assign commit_amt = (cur_ff.count > used_ff) ? used_ff : cur_ff.count;
   assign peek_amt   = (cur_ff.count > used_ff) ? used_ff : cur_ff.count;
   assign peek_n     = BATCH_W'(peek_amt);

   // read pointer advance by a commit, one compare and subtract
   assign rp_sum  = SUM_W'(rp_ff) + SUM_W'(commit_amt);
   assign rp_wrap = (rp_sum >= SUM_W'(RING_BYTES)) ? rp_sum - SUM_W'(RING_BYTES) : rp_sum;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd_data.func)
                  FUNC_PUSH:   state_in = ST_PUSH_LO;
                  FUNC_PEEK:   state_in = ST_PEEK;
                  FUNC_COMMIT: state_in = ST_COMMIT;
                  FUNC_CLEAR:  state_in = ST_CLEAR;
               endcase
            end
         end
         ST_PUSH_LO: state_in = ST_PUSH_HI;
         ST_PUSH_HI: state_in = ST_RESP;
         ST_COMMIT:  state_in = ST_RESP;
         ST_CLEAR:   state_in = ST_RESP;
         ST_PEEK:    state_in = (peek_n == '0) ? ST_RESP : ST_PEEK_DATA;
         ST_PEEK_DATA: begin
            if (out_load && last_byte) begin
               state_in = ST_IDLE;
            end
         end
         ST_RESP: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      wp_in       = wp_ff;
      rp_in       = rp_ff;
      used_in     = used_ff;
      dropped_in  = dropped_ff;
      recorded_in = recorded_ff;
      done_in     = done_ff;
      drop_in     = drop_ff;
      n_in        = n_ff;
      idx_in      = idx_ff;
      p_in        = p_ff;
      cmd_ready   = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = wp_ff;
      wr_data     = cur_ff.pcm[BYTE_W-1:0];
      rd_en       = 1'b0;
      rd_addr     = p_ff;
      emit        = 1'b0;

      rsp_in                = rsp_ff;
      rsp_in.data_byte      = '0;
      rsp_in.data_valid     = 1'b0;
      rsp_in.last           = 1'b1;
      rsp_in.count_done     = COUNT_W'(done_ff);
      rsp_in.bytes_used     = COUNT_W'(used_ff);
      rsp_in.dropped_total  = dropped_ff;
      rsp_in.recorded_total = recorded_ff;

      unique case (state_ff)
         ST_IDLE: begin
            cmd_ready = 1'b1;
         end
         ST_PUSH_LO: begin
            drop_in = full;
            done_in = '0;
            if (full) begin
               dropped_in = dropped_ff + TOTAL_W'(2);
            end else begin
               wr_en   = 1'b1;
               wp_in   = ptr_inc(wp_ff);
               used_in = used_ff + 1'b1;
               done_in = CNT_W'(1);
            end
         end
         ST_PUSH_HI: begin
            recorded_in = recorded_ff + TOTAL_W'(2);
            wr_data     = cur_ff.pcm[PCM_W-1:BYTE_W];
            if (!drop_ff) begin
               if (full) begin
                  dropped_in = dropped_ff + TOTAL_W'(1);
               end else begin
                  wr_en   = 1'b1;
                  wp_in   = ptr_inc(wp_ff);
                  used_in = used_ff + 1'b1;
                  done_in = done_ff + 1'b1;
               end
            end
         end
         ST_COMMIT: begin
            rp_in   = PTR_W'(rp_wrap);
            used_in = used_ff - commit_amt;
            done_in = commit_amt;
         end
         ST_CLEAR: begin
            wp_in       = '0;
            rp_in       = '0;
            used_in     = '0;
            dropped_in  = '0;
            recorded_in = '0;
            done_in     = '0;
         end
         ST_PEEK: begin
            n_in    = peek_n;
            idx_in  = '0;
            done_in = CNT_W'(peek_n);
            if (peek_n != '0) begin
               rd_en   = 1'b1;
               rd_addr = rp_ff;
               p_in    = ptr_inc(rp_ff);
            end
         end
         ST_PEEK_DATA: begin
            if (out_load) begin
               emit              = 1'b1;
               rsp_in.data_byte  = rd_data;
               rsp_in.data_valid = 1'b1;
               rsp_in.last       = last_byte;
               rsp_in.count_done = COUNT_W'(n_ff);
               if (!last_byte) begin
                  idx_in  = idx_ff + 1'b1;
                  rd_en   = 1'b1;
                  rd_addr = p_ff;
                  p_in    = ptr_inc(p_ff);
               end
            end
         end
         ST_RESP: begin
            emit = out_load;
         end
         default: begin
            cmd_ready = 1'b0;
         end
      endcase

      // response register handshake
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign cur_in = (state_ff == ST_IDLE && cmd_valid) ? cmd_data : cur_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         used_ff      <= '0;
         dropped_ff   <= '0;
         recorded_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         used_ff      <= used_in;
         dropped_ff   <= dropped_in;
         recorded_ff  <= recorded_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      done_ff <= done_in;
      drop_ff <= drop_in;
      n_ff    <= n_in;
      idx_ff  <= idx_in;
      p_ff    <= p_in;
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.data_byte      = rsp_ff.data_byte;
   assign rsp_bus.data_valid     = rsp_ff.data_valid;
   assign rsp_bus.last           = rsp_ff.last;
   assign rsp_bus.count_done     = rsp_ff.count_done;
   assign rsp_bus.bytes_used     = rsp_ff.bytes_used;
   assign rsp_bus.dropped_total  = rsp_ff.dropped_total;
   assign rsp_bus.recorded_total = rsp_ff.recorded_total;

   // checks
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_W'(RING_BYTES))
      else $error("fill count above ring size");

   a_port_excl: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("ring written and read in one cycle");

   a_wr_push: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_PUSH_LO || state_ff == ST_PUSH_HI))
      else $error("ring write outside a push");

   a_peek_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PEEK_DATA) |-> (n_ff != '0 && idx_ff < n_ff))
      else $error("peek index out of batch");

   a_drop_src: assert property (@(posedge clock) disable iff (reset)
      !$stable(dropped_ff) |-> ($past(reset) || $past(state_ff) == ST_PUSH_LO ||
                                $past(state_ff) == ST_PUSH_HI ||
                                $past(state_ff) == ST_CLEAR))
      else $error("drop counter moved outside push or clear");

endmodule

`default_nettype wire

// ===== sim/audio_sample_ring_buffer_test.sv =====
// Testbench for the audio sample ring buffer: self-checking stimulus and scoreboard.
`default_nettype none

module audio_sample_ring_buffer_test;
   import asrb_pkg::*;

   localparam int STALL_LIMIT = 5000;
   localparam int COUNT_MAX   = 65536;

   // Scoreboard: predicts the responses of each accepted request
   class pcm_ring_scoreboard;
      logic [BYTE_W-1:0]  ring_mem [RING_BYTES];
      logic [PTR_W-1:0]   wr_ptr;
      logic [PTR_W-1:0]   rd_ptr;
      logic [COUNT_W-1:0] held;
      logic [TOTAL_W-1:0] dropped;
      logic [TOTAL_W-1:0] recorded;
      logic [GAIN_W-1:0]  gain;
      rsp_type            pending_rsp [$];
      int                 errors;

      function new();
         clear_stream();
         gain   = GAIN_RESET;
         errors = 0;
      endfunction

      // Stream clear keeps the ring contents and the gain
      function void clear_stream();
         wr_ptr   = '0;
         rd_ptr   = '0;
         held     = '0;
         dropped  = '0;
         recorded = '0;
      endfunction

      function void set_gain(input logic [GAIN_W-1:0] value);
         gain = value;
      endfunction

      function int pending();
         return pending_rsp.size();
      endfunction

      function void add_rsp(input logic [BYTE_W-1:0] data, input logic valid,
                            input logic is_last, input logic [COUNT_W-1:0] done);
         rsp_type r;
         r.data_byte      = data;
         r.data_valid     = valid;
         r.last           = is_last;
         r.count_done     = done;
         r.bytes_used     = held;
         r.dropped_total  = dropped;
         r.recorded_total = recorded;
         pending_rsp.push_back(r);
      endfunction

      function void note_request(input func_type f, input logic [SLOT_W-1:0] slot,
                                 input logic [COUNT_W-1:0] cnt);
         int                 pcm_val;
         logic [PCM_W-1:0]   pcm_bits;
         logic [BYTE_W-1:0]  pair [2];
         logic [COUNT_W-1:0] written;
         logic [PTR_W-1:0]   p;
         int                 n;
         case (f)
            FUNC_PUSH: begin
               // scale upper half by gain, saturate to 16 bits
               pcm_val = int'($signed(slot[31:16])) * int'(gain);
               if (pcm_val > 32767) pcm_val = 32767;
               if (pcm_val < -32768) pcm_val = -32768;
               pcm_bits = pcm_val[PCM_W-1:0];
               pair[0]  = pcm_bits[7:0];
               pair[1]  = pcm_bits[15:8];
               written  = '0;
               for (int i = 0; i < 2; i++) begin
                  if (held >= RING_BYTES) begin
                     dropped = dropped + TOTAL_W'(2 - i);
                     break;
                  end
                  ring_mem[wr_ptr] = pair[i];
                  wr_ptr  = wr_ptr + 1'b1;
                  held    = held + 1'b1;
                  written = written + 1'b1;
               end
               recorded = recorded + TOTAL_W'(2);
               add_rsp('0, 1'b0, 1'b1, written);
            end
            FUNC_PEEK: begin
               n = int'(cnt);
               if (n > BATCH_MAX) n = BATCH_MAX;
               if (n > int'(held)) n = int'(held);
               if (n == 0) begin
                  add_rsp('0, 1'b0, 1'b1, '0);
               end else begin
                  p = rd_ptr;
                  for (int i = 0; i < n; i++) begin
                     add_rsp(ring_mem[p], 1'b1, i == n - 1, COUNT_W'(n));
                     p = p + 1'b1;
                  end
               end
            end
            FUNC_COMMIT: begin
               written = (cnt > held) ? held : cnt;
               rd_ptr  = rd_ptr + written[PTR_W-1:0];
               held    = held - written;
               add_rsp('0, 1'b0, 1'b1, written);
            end
            default: begin
               clear_stream();
               add_rsp('0, 1'b0, 1'b1, '0);
            end
         endcase
      endfunction

      function void compare_field(input string field, input logic [31:0] want,
                                  input logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            errors++;
         end
      endfunction

      function void check_response(input rsp_type got);
         rsp_type want;
         if (pending_rsp.size() == 0) begin
            $error("response with nothing pending: byte 0x%0h last %0b",
                   got.data_byte, got.last);
            errors++;
            return;
         end
         want = pending_rsp.pop_front();
         compare_field("data_byte", 32'(want.data_byte), 32'(got.data_byte));
         compare_field("data_valid", 32'(want.data_valid), 32'(got.data_valid));
         compare_field("last", 32'(want.last), 32'(got.last));
         compare_field("count_done", 32'(want.count_done), 32'(got.count_done));
         compare_field("bytes_used", 32'(want.bytes_used), 32'(got.bytes_used));
         compare_field("dropped_total", want.dropped_total, got.dropped_total);
         compare_field("recorded_total", want.recorded_total, got.recorded_total);
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   quiet;

   pcm_ring_scoreboard sb;

   asrb_req_if req_bus ();
   asrb_rsp_if rsp_bus ();
   asrb_csr_if csr_bus ();

   audio_sample_ring_buffer u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Response backpressure, off during quiet stretches
   always @(posedge clock) begin
      rsp_bus.ready <= (reset || quiet) ? 1'b1 : ($urandom_range(99) >= 19);
   end

   // Response monitor
   always @(posedge clock) begin
      rsp_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.data_byte      = rsp_bus.data_byte;
         got.data_valid     = rsp_bus.data_valid;
         got.last           = rsp_bus.last;
         got.count_done     = rsp_bus.count_done;
         got.bytes_used     = rsp_bus.bytes_used;
         got.dropped_total  = rsp_bus.dropped_total;
         got.recorded_total = rsp_bus.recorded_total;
         sb.check_response(got);
      end
   end

   // Watchdog: ends the run when no channel moves for too long
   initial begin : watchdog
      int stalled;
      stalled = 0;
      while (stalled < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready))
            stalled = 0;
         else
            stalled++;
      end
      $display("FAIL");
      $finish;
   end

   // One request; valid stays high afterwards unless the next call idles
   task automatic send_request(input func_type f, input logic [SLOT_W-1:0] slot,
                               input logic [COUNT_W-1:0] cnt);
      if (!quiet) begin
         while ($urandom_range(99) < 19) begin
            req_bus.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_bus.valid       <= 1'b1;
      req_bus.func        <= f;
      req_bus.sample_slot <= slot;
      req_bus.byte_count  <= cnt;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_request(f, slot, cnt);
   endtask

   // Hold off requests until every predicted response has arrived
   task automatic wait_for_responses();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Gain write; only called with the block drained
   task automatic write_gain(input logic [GAIN_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      sb.set_gain(value);
   endtask

   function automatic logic [SLOT_W-1:0] pick_slot();
      // mostly full range, some near zero so gain does not always saturate
      if ($urandom_range(9) < 7)
         return $urandom;
      return {16'($urandom_range(0, 1023)) - 16'd512, 16'($urandom)};
   endfunction

   function automatic logic [COUNT_W-1:0] pick_count();
      int r;
      int top;
      r = $urandom_range(9);
      if (r < 6)
         return COUNT_W'($urandom_range(0, 70));
      if (r < 9) begin
         top = int'(sb.held) + 8;
         if (top > COUNT_MAX) top = COUNT_MAX;
         return COUNT_W'($urandom_range(0, top));
      end
      return COUNT_W'($urandom_range(0, COUNT_MAX));
   endfunction

   // Mostly push bursts followed by a peek and sometimes a commit; some stray requests
   task automatic random_round(input int quota);
      int sent;
      int burst;
      sent = 0;
      while (sent < quota) begin
         if ($urandom_range(9) < 8) begin
            burst = $urandom_range(1, 6);
            repeat (burst) send_request(FUNC_PUSH, pick_slot(), pick_count());
            send_request(FUNC_PEEK, pick_slot(), pick_count());
            sent += burst + 1;
            if ($urandom_range(1)) begin
               send_request(FUNC_COMMIT, pick_slot(), pick_count());
               sent++;
            end
         end else begin
            send_request(func_type'($urandom_range(3)), $urandom, pick_count());
            sent++;
         end
      end
   endtask

   // Main sequence
   initial begin
      sb    = new();
      reset = 1'b1;
      quiet = 1'b0;
      req_bus.valid       = 1'b0;
      req_bus.func        = FUNC_PUSH;
      req_bus.sample_slot = '0;
      req_bus.byte_count  = '0;
      csr_bus.valid       = 1'b0;
      csr_bus.data        = '0;
      rsp_bus.ready       = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // empty ring, then the PCM extremes at unit gain
      send_request(FUNC_PEEK, '0, '0);
      send_request(FUNC_PEEK, '1, 17'd5);
      send_request(FUNC_COMMIT, '0, 17'd3);
      send_request(FUNC_PUSH, 32'h7FFF_FFFF, '1);
      send_request(FUNC_PUSH, 32'h8000_0000, '0);
      send_request(FUNC_PUSH, 32'h0001_FFFF, '0);
      send_request(FUNC_PUSH, 32'hFFFF_0000, '0);
      send_request(FUNC_PEEK, '0, 17'd65536);
      send_request(FUNC_PEEK, '0, 17'd3);
      send_request(FUNC_COMMIT, '0, 17'd1);
      send_request(FUNC_PEEK, '0, '0);
      send_request(FUNC_COMMIT, '0, 17'd65536);
      send_request(FUNC_CLEAR, 32'hFFFF_FFFF, '1);

      // full gain: saturation both ways
      wait_for_responses();
      write_gain(8'd255);
      send_request(FUNC_PUSH, 32'h0100_0000, '0);
      send_request(FUNC_PUSH, 32'hFF00_1234, '0);
      send_request(FUNC_PUSH, 32'h0080_0000, '0);
      send_request(FUNC_PUSH, 32'hFFFF_FFFF, '0);
      send_request(FUNC_PEEK, '0, 17'd64);

      // zero gain
      wait_for_responses();
      write_gain(8'd0);
      send_request(FUNC_PUSH, 32'h7FFF_0000, '0);
      send_request(FUNC_PEEK, '0, 17'd1);
      send_request(FUNC_COMMIT, '0, 17'd2);

      // clear, odd fill level, then a commit beyond what is held
      wait_for_responses();
      write_gain(GAIN_W'($urandom_range(0, 255)));
      send_request(FUNC_CLEAR, '0, '0);
      send_request(FUNC_PUSH, $urandom, '0);
      send_request(FUNC_COMMIT, '0, 17'd1);
      repeat (3) send_request(FUNC_PUSH, $urandom, '0);
      send_request(FUNC_PEEK, '0, 17'd65536);
      send_request(FUNC_COMMIT, '0, 17'd65536);
      send_request(FUNC_PUSH, $urandom, '0);
      send_request(FUNC_PEEK, '0, 17'd4);

      // random rounds under several gains, one without any idling
      wait_for_responses();
      write_gain(GAIN_W'($urandom_range(2, 254)));
      random_round(17);
      wait_for_responses();
      write_gain(GAIN_RESET);
      quiet = 1'b1;
      random_round(17);
      wait_for_responses();
      quiet = 1'b0;
      write_gain(8'd255);
      random_round(17);
      wait_for_responses();
      write_gain(GAIN_W'($urandom_range(0, 255)));
      random_round(17);

      // drain and let any stray response show up
      wait_for_responses();
      repeat (16) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
design/asrb_pkg.sv
design/asrb_if.sv
design/asrb_ram.sv
design/asrb_front.sv
design/asrb_queue.sv
design/asrb_back.sv
design/audio_sample_ring_buffer.sv
sim/audio_sample_ring_buffer_test.sv
